@@ rtl/nfr_pkg.sv @@
// ----------------------------------------------------------------------------
// nfr_pkg
// Shared constants, types and helpers for the notification frame reassembler.
// ----------------------------------------------------------------------------
package nfr_pkg;

   localparam int FRAME_LENGTH_DEFAULT = 300;
   localparam int BYTE_WIDTH           = 8;
   localparam int POS_WIDTH            = 9;
   localparam int KIND_WIDTH           = 2;
   localparam int MATCH_WIDTH          = 2;

   // opening sequence of a frame
   localparam logic [BYTE_WIDTH-1:0] SYNC_0 = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] SYNC_1 = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] SYNC_2 = 8'hEB;
   localparam logic [BYTE_WIDTH-1:0] SYNC_3 = 8'h90;
   localparam logic [BYTE_WIDTH-1:0] SYNC_SUM = BYTE_WIDTH'(SYNC_0 + SYNC_1 + SYNC_2 + SYNC_3);
   localparam logic [MATCH_WIDTH-1:0] SYNC_LAST_IDX = 2'd3;
   localparam logic [POS_WIDTH-1:0]   FIRST_BODY_POS = 9'd4;
   localparam logic [POS_WIDTH-1:0]   TYPE_POS       = 9'd4;
   localparam logic [POS_WIDTH-1:0]   COUNT_POS      = 9'd5;

   // type byte codes
   localparam logic [BYTE_WIDTH-1:0] TYPE_CONFIG_INFO = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] TYPE_CELL_DATA   = 8'h02;
   localparam logic [BYTE_WIDTH-1:0] TYPE_DEVICE_INFO = 8'h03;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_CONFIG_INFO = 2'd0,
      KIND_CELL_DATA   = 2'd1,
      KIND_DEVICE_INFO = 2'd2,
      KIND_UNKNOWN     = 2'd3
   } frame_kind_type;

   // one pending response: either the four-byte opening burst or a single byte
   typedef struct packed {
      logic                  valid;
      logic                  opening;
      logic [BYTE_WIDTH-1:0] out_byte;
      logic [POS_WIDTH-1:0]  byte_position;
      logic                  frame_end;
      logic                  checksum_ok;
      frame_kind_type        frame_kind;
      logic [BYTE_WIDTH-1:0] frame_count;
   } rsp_desc_type;

   function automatic logic [BYTE_WIDTH-1:0] sync_byte(input logic [MATCH_WIDTH-1:0] idx);
      logic [BYTE_WIDTH-1:0] b;
      unique case (idx)
         2'd0:    b = SYNC_0;
         2'd1:    b = SYNC_1;
         2'd2:    b = SYNC_2;
         default: b = SYNC_3;
      endcase
      return b;
   endfunction

   function automatic frame_kind_type classify(input logic [BYTE_WIDTH-1:0] t);
      frame_kind_type k;
      unique case (t)
         TYPE_CONFIG_INFO: k = KIND_CONFIG_INFO;
         TYPE_CELL_DATA:   k = KIND_CELL_DATA;
         TYPE_DEVICE_INFO: k = KIND_DEVICE_INFO;
         default:          k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/nfr_channels.sv @@
// ----------------------------------------------------------------------------
// nfr channel interfaces
// Valid/ready request and response channels of the frame reassembler.
// ----------------------------------------------------------------------------
interface nfr_req_if;
   logic                           valid;
   logic                           ready;
   logic [nfr_pkg::BYTE_WIDTH-1:0] data_byte;
   logic                           packet_start;

   modport source (output valid, output data_byte, output packet_start, input ready);
   modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

interface nfr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nfr_pkg::BYTE_WIDTH-1:0]  out_byte;
   logic [nfr_pkg::POS_WIDTH-1:0]   byte_position;
   logic                            run_last;
   logic                            frame_end;
   logic                            checksum_ok;
   logic [nfr_pkg::KIND_WIDTH-1:0]  frame_kind;
   logic [nfr_pkg::BYTE_WIDTH-1:0]  frame_count;

   modport source (output valid, output out_byte, output byte_position, output run_last,
                   output frame_end, output checksum_ok, output frame_kind,
                   output frame_count, input ready);
   modport sink   (input valid, input out_byte, input byte_position, input run_last,
                   input frame_end, input checksum_ok, input frame_kind,
                   input frame_count, output ready);
endinterface

@@ rtl/nfr_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// nfr_frame_tracker
// Hunts for the opening sequence, tracks frame position and checksum, and
// produces at most one valid response descriptor per accepted request.
// ----------------------------------------------------------------------------
module nfr_frame_tracker #(
   parameter int FRAME_LENGTH = nfr_pkg::FRAME_LENGTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   input  logic                           req_fire,
   input  logic [nfr_pkg::BYTE_WIDTH-1:0] data_byte,
   input  logic                           packet_start,
   output nfr_pkg::rsp_desc_type          desc
);

   localparam logic [nfr_pkg::POS_WIDTH-1:0] LAST_POS = nfr_pkg::POS_WIDTH'(FRAME_LENGTH - 1);

   logic                              enable_ff;
   logic                              capturing_ff, capturing_in;
   logic [nfr_pkg::MATCH_WIDTH-1:0]   match_ff, match_in;
   logic [nfr_pkg::POS_WIDTH-1:0]     fill_ff, fill_in;
   logic [nfr_pkg::BYTE_WIDTH-1:0]    sum_ff, sum_in;
   logic [nfr_pkg::BYTE_WIDTH-1:0]    type_ff, type_in;
   logic [nfr_pkg::BYTE_WIDTH-1:0]    count_ff, count_in;

   always_comb begin
      capturing_in = capturing_ff;
      match_in     = match_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      type_in      = type_ff;
      count_in     = count_ff;

      desc               = '0;
      desc.out_byte      = data_byte;
      desc.byte_position = fill_ff;
      desc.frame_kind    = nfr_pkg::KIND_CONFIG_INFO;

      if (req_fire && enable_ff) begin
         if (!capturing_ff) begin
            if (packet_start) begin
               match_in = (data_byte == nfr_pkg::SYNC_0) ? 2'd1 : 2'd0;
            end else if (match_ff == 2'd0 || data_byte != nfr_pkg::sync_byte(match_ff)) begin
               match_in = 2'd0;
            end else if (match_ff == nfr_pkg::SYNC_LAST_IDX) begin
               // full opening sequence: open the frame and emit the burst
               desc.valid   = 1'b1;
               desc.opening = 1'b1;
               match_in     = 2'd0;
               capturing_in = 1'b1;
               fill_in      = nfr_pkg::FIRST_BODY_POS;
               sum_in       = nfr_pkg::SYNC_SUM;
               type_in      = '0;
               count_in     = '0;
            end else begin
               match_in = match_ff + 2'd1;
            end
         end else if (fill_ff >= LAST_POS) begin
            desc.valid       = 1'b1;
            desc.frame_end   = 1'b1;
            desc.checksum_ok = (sum_ff == data_byte);
            desc.frame_kind  = nfr_pkg::classify(type_ff);
            desc.frame_count = count_ff;
            capturing_in     = 1'b0;
            match_in         = 2'd0;
            fill_in          = '0;
            sum_in           = '0;
         end else begin
            desc.valid = 1'b1;
            if (fill_ff == nfr_pkg::TYPE_POS)  type_in  = data_byte;
            if (fill_ff == nfr_pkg::COUNT_POS) count_in = data_byte;
            sum_in  = sum_ff + data_byte;
            fill_in = fill_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         capturing_ff <= 1'b0;
         match_ff     <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         type_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
         capturing_ff <= capturing_in;
         match_ff     <= match_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         type_ff      <= type_in;
         count_ff     <= count_in;
      end
   end

endmodule

@@ rtl/nfr_rsp_serializer.sv @@
// ----------------------------------------------------------------------------
// nfr_rsp_serializer
// Response register: holds one descriptor and plays it out, expanding the
// opening burst into four responses.
// ----------------------------------------------------------------------------
module nfr_rsp_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  nfr_pkg::rsp_desc_type           desc,
   output logic                            load_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [nfr_pkg::BYTE_WIDTH-1:0]  rsp_out_byte,
   output logic [nfr_pkg::POS_WIDTH-1:0]   rsp_byte_position,
   output logic                            rsp_run_last,
   output logic                            rsp_frame_end,
   output logic                            rsp_checksum_ok,
   output logic [nfr_pkg::KIND_WIDTH-1:0]  rsp_frame_kind,
   output logic [nfr_pkg::BYTE_WIDTH-1:0]  rsp_frame_count
);

   logic                            valid_ff;
   logic [nfr_pkg::MATCH_WIDTH-1:0] beat_ff;
   nfr_pkg::rsp_desc_type           desc_ff;
   logic                            last_beat;

   assign last_beat  = !desc_ff.opening || (beat_ff == nfr_pkg::SYNC_LAST_IDX);
   assign load_ready = !valid_ff || (rsp_ready && last_beat);

   always_comb begin
      rsp_valid         = valid_ff;
      rsp_out_byte      = desc_ff.out_byte;
      rsp_byte_position = desc_ff.byte_position;
      rsp_run_last      = last_beat;
      rsp_frame_end     = desc_ff.frame_end;
      rsp_checksum_ok   = desc_ff.checksum_ok;
      rsp_frame_kind    = desc_ff.frame_kind;
      rsp_frame_count   = desc_ff.frame_count;
      if (desc_ff.opening) begin
         rsp_out_byte      = nfr_pkg::sync_byte(beat_ff);
         rsp_byte_position = nfr_pkg::POS_WIDTH'(beat_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else if (load) begin
         valid_ff <= desc.valid;
         beat_ff  <= '0;
      end else if (valid_ff && rsp_ready) begin
         if (last_beat) begin
            valid_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= desc;
      end
   end

endmodule

@@ rtl/notification_frame_reassembler_unit.sv @@
// ----------------------------------------------------------------------------
// notification_frame_reassembler_unit
// Rebuilds fixed-length frames from link-packet bytes: sync hunt, position,
// additive checksum, type class and counter on the final byte.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    data_byte, packet_start
//   rsp_chan  out   valid/ready    out_byte, byte_position, run_last,
//                                  frame_end, checksum_ok, frame_kind,
//                                  frame_count
//   csr_*     in    write enable   capture_enable
//
// One request per cycle while the response register can take it; a request that
// opens a frame yields four responses, every other request yields at most one.
// A request is taken whenever the response register is empty or its last
// response leaves in the same cycle, so a stalled response holds the input.
// Synchronous active-high reset returns to hunting with capture disabled.
// ----------------------------------------------------------------------------
module notification_frame_reassembler_unit #(
   parameter int FRAME_LENGTH = nfr_pkg::FRAME_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   nfr_req_if.sink    req_chan,
   nfr_rsp_if.source  rsp_chan,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   nfr_pkg::rsp_desc_type desc;
   logic                  req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   nfr_frame_tracker #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_fire         (req_fire),
      .data_byte        (req_chan.data_byte),
      .packet_start     (req_chan.packet_start),
      .desc             (desc)
   );

   nfr_rsp_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .load              (req_fire),
      .desc              (desc),
      .load_ready        (req_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_out_byte      (rsp_chan.out_byte),
      .rsp_byte_position (rsp_chan.byte_position),
      .rsp_run_last      (rsp_chan.run_last),
      .rsp_frame_end     (rsp_chan.frame_end),
      .rsp_checksum_ok   (rsp_chan.checksum_ok),
      .rsp_frame_kind    (rsp_chan.frame_kind),
      .rsp_frame_count   (rsp_chan.frame_count)
   );

   // frame end is always a single response
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_end |-> rsp_chan.run_last)
      else $error("frame end inside a burst");

   // only the opening burst has non-last responses, at positions 0..2
   a_burst_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.run_last |-> rsp_chan.byte_position < 9'd3)
      else $error("burst response at wrong position");

   // a burst continues with the next position
   a_burst_step: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.run_last |=>
         rsp_chan.valid &&
         rsp_chan.byte_position == $past(rsp_chan.byte_position) + 9'd1)
      else $error("burst broken");

   // an empty response register never blocks requests
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request blocked while idle");

endmodule
